>>> hw/rtl/kptc_pkg.sv
package kptc_pkg;

    // Key values after table lookup (digits 0..9 use their own value)
    localparam logic [3:0] KEY_ENTER  = 4'd10;
    localparam logic [3:0] KEY_CANCEL = 4'd11;

    // Scale register value after reset
    localparam logic [7:0] DUTY_SCALE_RESET = 8'd120;

    // Raw matrix codes: column mask in the high nibble, row one-hot in the low
    localparam logic [7:0] CODE_K3     = 8'h11;
    localparam logic [7:0] CODE_K2     = 8'h21;
    localparam logic [7:0] CODE_K1     = 8'h41;
    localparam logic [7:0] CODE_K6     = 8'h12;
    localparam logic [7:0] CODE_K5     = 8'h22;
    localparam logic [7:0] CODE_K4     = 8'h42;
    localparam logic [7:0] CODE_K9     = 8'h14;
    localparam logic [7:0] CODE_K8     = 8'h24;
    localparam logic [7:0] CODE_K7     = 8'h44;
    localparam logic [7:0] CODE_ENTER  = 8'h18;
    localparam logic [7:0] CODE_K0     = 8'h28;
    localparam logic [7:0] CODE_CANCEL = 8'h48;

    // Wrap values for the time digits when a borrow passes through them
    localparam logic [3:0] MINUTE_UNITS_WRAP = 4'd9;
    localparam logic [3:0] TENS_WRAP         = 4'd5;
    localparam logic [3:0] UNITS_WRAP        = 4'd9;

    localparam int TIME_DIGITS = 6;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POWER = 3'd1,
        PH_TIME  = 3'd2,
        PH_READY = 3'd3,
        PH_RUN   = 3'd4
    } phase_t;

    // Architectural state of the controller
    typedef struct packed {
        phase_t                          phase;
        logic [1:0]                      entry_pos;
        logic [1:0][3:0]                 power_digits;
        logic [TIME_DIGITS-1:0][3:0]     time_digits;
        logic [3:0]                      last_key;
        logic                            counting;
        logic                            drive;
        logic                            led;
        logic [14:0]                     compare;
    } state_t;

    // Look up a raw code; bit 4 flags a known code, bits 3:0 give its value
    function automatic logic [4:0] key_lookup(input logic [7:0] code);
        logic [4:0] res;
        res = 5'd0;
        unique case (code)
            CODE_K3:     res = {1'b1, 4'd3};
            CODE_K2:     res = {1'b1, 4'd2};
            CODE_K1:     res = {1'b1, 4'd1};
            CODE_K6:     res = {1'b1, 4'd6};
            CODE_K5:     res = {1'b1, 4'd5};
            CODE_K4:     res = {1'b1, 4'd4};
            CODE_K9:     res = {1'b1, 4'd9};
            CODE_K8:     res = {1'b1, 4'd8};
            CODE_K7:     res = {1'b1, 4'd7};
            CODE_ENTER:  res = {1'b1, KEY_ENTER};
            CODE_K0:     res = {1'b1, 4'd0};
            CODE_CANCEL: res = {1'b1, KEY_CANCEL};
            default:     res = 5'd0;
        endcase
        return res;
    endfunction

    // Power percent from the two entered digits
    function automatic logic [6:0] percent(input logic [1:0][3:0] d);
        logic [6:0] tens;
        tens = {3'd0, d[0]};
        return 7'((tens << 3) + (tens << 1) + {3'd0, d[1]});
    endfunction

endpackage

>>> hw/rtl/kptc_next.sv
module kptc_next (
    input  kptc_pkg::state_t state_cur,
    input  logic             mode,
    input  logic [7:0]       scan_code,
    input  logic [7:0]       duty_scale,
    output kptc_pkg::state_t state_nxt
);

    logic [4:0]                              lookup;
    logic [3:0]                              key_val;
    logic [kptc_pkg::TIME_DIGITS-1:0][3:0]   dec_digits;
    logic                                    time_zero;
    logic                                    dec_zero;
    logic [6:0]                              pct;
    logic [14:0]                             product;

    // Resolve the pressed key, falling back to the last one on a miss
    assign lookup  = kptc_pkg::key_lookup(scan_code);
    assign key_val = lookup[4] ? lookup[3:0] : state_cur.last_key;

    assign pct     = kptc_pkg::percent(state_cur.power_digits);
    assign product = 15'({7'd0, duty_scale} * {8'd0, pct});

    assign time_zero = (state_cur.time_digits == '0);

    // Borrowing BCD countdown, seconds units first
    always_comb
    begin
        logic borrow;
        logic [3:0] wrap;
        dec_digits = state_cur.time_digits;
        borrow     = 1'b1;
        for (int k = kptc_pkg::TIME_DIGITS - 1; k >= 0; k--)
        begin
            unique case (k)
                5:       wrap = kptc_pkg::UNITS_WRAP;
                4:       wrap = kptc_pkg::TENS_WRAP;
                3:       wrap = kptc_pkg::MINUTE_UNITS_WRAP;
                2:       wrap = kptc_pkg::TENS_WRAP;
                1:       wrap = kptc_pkg::UNITS_WRAP;
                default: wrap = 4'd0;
            endcase
            if (borrow)
            begin
                if (k > 0 && state_cur.time_digits[k] == 4'd0)
                begin
                    dec_digits[k] = wrap;
                end
                else
                begin
                    dec_digits[k] = state_cur.time_digits[k] - 4'd1;
                    borrow        = 1'b0;
                end
            end
        end
    end

    assign dec_zero = (dec_digits == '0);

    // Next state for one press or tick
    always_comb
    begin
        kptc_pkg::state_t cleared;
        logic [1:0] pos_inc;

        cleared           = '0;
        cleared.phase     = kptc_pkg::PH_IDLE;
        cleared.last_key  = state_cur.last_key;

        state_nxt = state_cur;
        pos_inc   = state_cur.entry_pos + 2'd1;

        if (!mode)
        begin
            cleared.last_key   = key_val;
            state_nxt.last_key = key_val;
            if (key_val == kptc_pkg::KEY_CANCEL)
            begin
                state_nxt = cleared;
            end
            else
            begin
                // Any digit wakes the block from idle
                if (state_cur.phase == kptc_pkg::PH_IDLE && key_val != kptc_pkg::KEY_ENTER)
                begin
                    state_nxt.phase = kptc_pkg::PH_POWER;
                end

                if (state_nxt.phase == kptc_pkg::PH_POWER
                    && key_val != kptc_pkg::KEY_ENTER)
                begin
                    state_nxt.power_digits[state_cur.entry_pos[0]] = key_val;
                    if (pos_inc > 2'd1)
                    begin
                        state_nxt.entry_pos = 2'd0;
                        state_nxt.phase     = kptc_pkg::PH_TIME;
                    end
                    else
                    begin
                        state_nxt.entry_pos = pos_inc;
                    end
                end
                else if (state_nxt.phase == kptc_pkg::PH_TIME
                         && key_val != kptc_pkg::KEY_ENTER)
                begin
                    state_nxt.time_digits[{1'b0, state_cur.entry_pos}] = key_val;
                    if (state_cur.entry_pos == 2'd3)
                    begin
                        state_nxt.entry_pos = 2'd0;
                        state_nxt.phase     = kptc_pkg::PH_READY;
                    end
                    else
                    begin
                        state_nxt.entry_pos = pos_inc;
                    end
                end
                else if (state_nxt.phase == kptc_pkg::PH_READY
                         && key_val == kptc_pkg::KEY_ENTER)
                begin
                    state_nxt.drive     = 1'b1;
                    state_nxt.counting  = 1'b1;
                    state_nxt.compare   = product;
                    state_nxt.phase     = kptc_pkg::PH_RUN;
                    state_nxt.entry_pos = 2'd0;
                end

                if (state_nxt.phase == kptc_pkg::PH_RUN)
                begin
                    state_nxt.entry_pos = 2'd0;
                end
            end
        end
        else
        begin
            // Tick: count down while running, toggle the LED in run, end the run at zero
            if (state_cur.counting && time_zero)
            begin
                state_nxt = cleared;
            end
            else if (state_cur.counting && dec_zero)
            begin
                state_nxt = cleared;
            end
            else
            begin
                if (state_cur.counting)
                begin
                    state_nxt.time_digits = dec_digits;
                end
                if (state_cur.phase == kptc_pkg::PH_RUN)
                begin
                    state_nxt.led = !state_cur.led;
                end
            end
        end
    end

endmodule

>>> hw/rtl/keypad_power_timer_controller.sv
// Pipeline: one input register, then one result register that drives m_tdata.
// Throughput: one word per cycle unless m_tready holds a result back; the state
// register is updated from combinational next-state logic.
// Reset (rst_n low, asynchronous): idle, all digits and flags zero, last key
// digit 0, duty_scale 120, no word held in either register.
module keypad_power_timer_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,    // duty_scale
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // scan_code
    input  logic        s_tuser,      // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata       // phase[2:0], power_percent[9:3],
                                      // hour_tens[13:10], hour_units[17:14],
                                      // minute_tens[21:18], minute_units[25:22],
                                      // second_tens[28:26], second_units[32:29],
                                      // duty_count[47:33], heating_on[48],
                                      // led_state[49], zero fill[55:50]
);

    logic             in_valid_reg;
    logic             in_mode_reg;
    logic [7:0]       in_code_reg;
    logic             out_valid_reg;
    logic [55:0]      out_data_reg;
    logic [55:0]      out_data_next;
    logic [7:0]       duty_scale_reg;
    kptc_pkg::state_t state_reg;
    kptc_pkg::state_t state_next;
    logic             advance;

    // Process the held word when the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    kptc_next u_next (
        .state_cur  (state_reg),
        .mode       (in_mode_reg),
        .scan_code  (in_code_reg),
        .duty_scale (duty_scale_reg),
        .state_nxt  (state_next)
    );

    // Pack the result word
    assign out_data_next = {
        6'd0,
        state_next.led,
        state_next.drive,
        state_next.compare,
        state_next.time_digits[5],
        state_next.time_digits[4][2:0],
        state_next.time_digits[3],
        state_next.time_digits[2],
        state_next.time_digits[1],
        state_next.time_digits[0],
        kptc_pkg::percent(state_next.power_digits),
        state_next.phase
    };

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_scale_reg <= kptc_pkg::DUTY_SCALE_RESET;
        end
        else if (cfg_wen)
        begin
            duty_scale_reg <= cfg_wdata;
        end
    end

    // Capture input words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_code_reg <= s_tdata;
        end
    end

    // Advance controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_run_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == kptc_pkg::PH_RUN) |-> (state_reg.drive && state_reg.counting))
        else $error("running without drive or countdown");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != kptc_pkg::PH_RUN)
        |-> (state_reg.compare == 15'd0 && !state_reg.drive && !state_reg.led))
        else $error("drive, compare or LED active outside run");

    a_sec_tens: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.time_digits[4] <= kptc_pkg::TENS_WRAP)
        else $error("seconds tens digit out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && out_data_reg[2:0] == state_reg.phase))
        else $error("result word does not match updated state");
`endif

endmodule
